### hw/rtl/pida_pkg.sv
package pida_pkg;

	localparam int DATA_W    = 32;
	localparam int CMD_W     = 3;
	localparam int POS_W     = 5;
	localparam int STAT_W    = 2;
	localparam int IDX_OUT_W = 4;
	localparam int CNT_OUT_W = 5;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_TRAVERSE  = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_LEFT,
		OP_RIGHT,
		OP_HEAD
	} cell_op_t;

endpackage

### hw/rtl/pida_cell.sv
module pida_cell (
	input  logic                                 clk,
	input  pida_pkg::cell_op_t                   op,
	input  logic signed [pida_pkg::DATA_W-1:0]   ins_data,
	input  logic signed [pida_pkg::DATA_W-1:0]   left_data,
	input  logic signed [pida_pkg::DATA_W-1:0]   right_data,
	input  logic signed [pida_pkg::DATA_W-1:0]   head_data,
	output logic signed [pida_pkg::DATA_W-1:0]   cell_data
);
	import pida_pkg::*;

	logic signed [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD:  data_q <= ins_data;
			OP_LEFT:  data_q <= left_data;
			OP_RIGHT: data_q <= right_data;
			OP_HEAD:  data_q <= head_data;
			default:  data_q <= data_q;
		endcase
	end

	assign cell_data = data_q;

endmodule

### hw/rtl/pida_ctrl.sv
module pida_ctrl #(
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [pida_pkg::CMD_W-1:0]            command,
	input  logic [pida_pkg::POS_W-1:0]            position,
	input  logic signed [pida_pkg::DATA_W-1:0]    value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pida_pkg::STAT_W-1:0]           status,
	output logic signed [pida_pkg::DATA_W-1:0]    data,
	output logic [pida_pkg::IDX_OUT_W-1:0]        index,
	output logic [pida_pkg::CNT_OUT_W-1:0]        count,
	output logic                                  last,
	input  logic signed [pida_pkg::DATA_W-1:0]    head_data,
	output pida_pkg::cell_op_t                    ops [DEPTH],
	output logic signed [pida_pkg::DATA_W-1:0]    ins_data
);
	import pida_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IW   = $clog2(DEPTH);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic {
		S_IDLE,
		S_TRAV
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       fill_q;
	logic [IW-1:0]       idx_q;
	logic                out_valid_q;
	logic [STAT_W-1:0]   status_q;
	logic signed [DATA_W-1:0] data_q;
	logic [IDX_OUT_W-1:0] index_q;
	logic [CNT_OUT_W-1:0] count_q;
	logic                last_q;

	logic                out_free;
	logic                accept;
	logic [CMPW-1:0]     pos_x;
	logic [CMPW-1:0]     cnt_x;
	logic [CMPW-1:0]     ins_pos;
	logic                is_full;
	logic                is_empty;
	logic                trav_start;
	logic                trav_emit;
	logic [IW-1:0]       trav_idx;
	logic                trav_last;
	logic                do_ins;
	logic                do_del;
	logic [STAT_W-1:0]   st;
	logic [CW-1:0]       fill_d;

	always_comb begin
		out_free   = !out_valid_q || !out_stall;
		in_stall   = (state_q == S_TRAV) || !out_free;
		accept     = in_valid && !in_stall;
		pos_x      = CMPW'(position);
		cnt_x      = CMPW'(fill_q);
		is_full    = (fill_q == CW'(DEPTH));
		is_empty   = (fill_q == '0);
		trav_start = accept && (command == CMD_TRAVERSE) && !is_empty;
		trav_emit  = out_free && ((state_q == S_TRAV) || trav_start);
		trav_idx   = (state_q == S_TRAV) ? idx_q : '0;
		trav_last  = ((CW'(trav_idx) + CW'(1)) == fill_q);
		ins_pos    = (command == CMD_INS_FRONT) ? '0 : pos_x;
		do_ins     = 1'b0;
		do_del     = 1'b0;
		st         = STAT_OK;
		fill_d     = fill_q;
		if (accept) begin
			unique case (command)
				CMD_INS_FRONT, CMD_INS_AT: begin
					if (is_full) begin
						st = STAT_FULL;
					end else if (ins_pos > cnt_x) begin
						st = STAT_BADPOS;
					end else begin
						do_ins = 1'b1;
						fill_d = fill_q + CW'(1);
					end
				end
				CMD_DEL_LAST: begin
					if (is_empty) begin
						st = STAT_EMPTY;
					end else begin
						fill_d = fill_q - CW'(1);
					end
				end
				CMD_DEL_AT: begin
					if (is_empty) begin
						st = STAT_EMPTY;
					end else if (pos_x >= cnt_x) begin
						st = STAT_BADPOS;
					end else begin
						do_del = 1'b1;
						fill_d = fill_q - CW'(1);
					end
				end
				CMD_TRAVERSE: begin
					if (is_empty) begin
						st = STAT_EMPTY;
					end
				end
				default: begin
					st = STAT_OK;
				end
			endcase
		end
		for (int i = 0; i < DEPTH; i++) begin
			ops[i] = OP_HOLD;
			if (do_ins) begin
				if (CMPW'(i) > ins_pos) begin
					ops[i] = OP_LEFT;
				end else if (CMPW'(i) == ins_pos) begin
					ops[i] = OP_LOAD;
				end
			end else if (do_del) begin
				if (CMPW'(i) >= pos_x) begin
					ops[i] = OP_RIGHT;
				end
			end else if (trav_emit) begin
				if ((CMPW'(i) + CMPW'(1)) < cnt_x) begin
					ops[i] = OP_RIGHT;
				end else if ((CMPW'(i) + CMPW'(1)) == cnt_x) begin
					ops[i] = OP_HEAD;
				end
			end
		end
	end

	assign ins_data = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			data_q      <= '0;
			index_q     <= '0;
			count_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (accept && !trav_start) begin
				out_valid_q <= 1'b1;
				status_q    <= st;
				data_q      <= '0;
				index_q     <= '0;
				count_q     <= CNT_OUT_W'(fill_d);
				last_q      <= 1'b1;
			end else if (trav_emit) begin
				out_valid_q <= 1'b1;
				status_q    <= STAT_OK;
				data_q      <= head_data;
				index_q     <= IDX_OUT_W'(trav_idx);
				count_q     <= CNT_OUT_W'(fill_q);
				last_q      <= trav_last;
				idx_q       <= trav_idx + IW'(1);
				state_q     <= trav_last ? S_IDLE : S_TRAV;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign data      = data_q;
	assign index     = index_q;
	assign count     = count_q;
	assign last      = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == $past(fill_q) || fill_q == $past(fill_q) + CW'(1) ||
		fill_q == $past(fill_q) - CW'(1))
		else $error("fill count moved by more than one");

	a_midtrav: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> state_q == S_TRAV)
		else $error("non-final item outside traverse");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != STAT_OK |-> last_q && data_q == '0)
		else $error("error item not single");

	a_trav_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TRAV |-> fill_q == $past(fill_q))
		else $error("store count changed during traverse");

endmodule

### hw/rtl/positional_insert_delete_array.sv
// An accepted item's first result item appears in the cycle after it is taken.
// Insert and delete-at shift all cells from the position up at once.
// Traverse gives one result item per held element, one per cycle while
// out_stall is low, and takes no new item until its last result is registered.
// Reset (arst_n low, asynchronous) empties the store; element contents stay
// undefined until written.
module positional_insert_delete_array #(
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [pida_pkg::CMD_W-1:0]            command,
	input  logic [pida_pkg::POS_W-1:0]            position,
	input  logic signed [pida_pkg::DATA_W-1:0]    value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [pida_pkg::STAT_W-1:0]           status,
	output logic signed [pida_pkg::DATA_W-1:0]    data,
	output logic [pida_pkg::IDX_OUT_W-1:0]        index,
	output logic [pida_pkg::CNT_OUT_W-1:0]        count,
	output logic                                  last
);
	import pida_pkg::*;

	cell_op_t                 ops [DEPTH];
	logic signed [DATA_W-1:0] cell_q [DEPTH];
	logic signed [DATA_W-1:0] ins_data;

	pida_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.position  (position),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.data      (data),
		.index     (index),
		.count     (count),
		.last      (last),
		.head_data (cell_q[0]),
		.ops       (ops),
		.ins_data  (ins_data)
	);

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;

		if (g == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_q[g-1];
		end

		if (g == DEPTH - 1) begin : g_lastc
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_q[g+1];
		end

		pida_cell u_cell (
			.clk        (clk),
			.op         (ops[g]),
			.ins_data   (ins_data),
			.left_data  (left_d),
			.right_data (right_d),
			.head_data  (cell_q[0]),
			.cell_data  (cell_q[g])
		);
	end

endmodule
